### src/trs_world_matrix_compose_assert.svh
// Assertion macros for the world matrix compose block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef TRS_WORLD_MATRIX_COMPOSE_ASSERT_SVH
`define TRS_WORLD_MATRIX_COMPOSE_ASSERT_SVH

// Same-cycle implication.
`define TWMC_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define TWMC_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### src/twmc_pkg.sv
// Shared constants, types and tables for the world matrix compose block.
// No dependencies.
`default_nettype none

package twmc_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_BITS = 16;
   localparam int Q30_SHIFT = 30 - FRAC_BITS;

   localparam int RED_W = 48;
   localparam int CRD_W = 36;
   localparam int CORDIC_STEPS = 24;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1 << FRAC_BITS);

   localparam logic signed [RED_W-1:0] Q30_TWO_PI = 48'sd6746518852;
   localparam logic signed [RED_W-1:0] Q30_PI = 48'sd3373259426;
   localparam logic signed [RED_W-1:0] Q30_HALF_PI = 48'sd1686629713;
   localparam logic signed [CRD_W-1:0] Q30_GAIN = 36'sd652032874;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_CHILD = 2'd1;
   localparam logic [1:0] CMD_ROOT = 2'd2;
   localparam logic [1:0] CMD_SKIP = 2'd3;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic     done;
      word_type sin_v;
      word_type cos_v;
   } cordic_out_type;

   typedef struct packed {
      logic     done;
      word_type prod;
   } mul_out_type;

   function automatic logic signed [CRD_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [CRD_W-1:0] v;
      case (i)
         5'd0:    v = 36'sd843314857;
         5'd1:    v = 36'sd497837829;
         5'd2:    v = 36'sd263043837;
         5'd3:    v = 36'sd133525159;
         5'd4:    v = 36'sd67021687;
         5'd5:    v = 36'sd33543516;
         5'd6:    v = 36'sd16775851;
         5'd7:    v = 36'sd8388437;
         5'd8:    v = 36'sd4194283;
         5'd9:    v = 36'sd2097149;
         5'd10:   v = 36'sd1048576;
         5'd11:   v = 36'sd524288;
         5'd12:   v = 36'sd262144;
         5'd13:   v = 36'sd131072;
         5'd14:   v = 36'sd65536;
         5'd15:   v = 36'sd32768;
         5'd16:   v = 36'sd16384;
         5'd17:   v = 36'sd8192;
         5'd18:   v = 36'sd4096;
         5'd19:   v = 36'sd2048;
         5'd20:   v = 36'sd1024;
         5'd21:   v = 36'sd512;
         5'd22:   v = 36'sd256;
         5'd23:   v = 36'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### src/twmc_cordic.sv
// Sine and cosine unit: restoring modulo-2pi reduction, fold, 24 CORDIC steps.
// Depends on twmc_pkg.
`default_nettype none

module twmc_cordic (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire twmc_pkg::word_type angle,
   output twmc_pkg::cordic_out_type result
);
   import twmc_pkg::*;

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_RED  = 3'd1;
   localparam logic [2:0] C_FIX  = 3'd2;
   localparam logic [2:0] C_WRAP = 3'd3;
   localparam logic [2:0] C_FOLD = 3'd4;
   localparam logic [2:0] C_ITER = 3'd5;
   localparam logic [2:0] C_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [4:0] i_ff, i_in;
   logic zneg_ff, zneg_in, flip_ff, flip_in;
   logic signed [RED_W-1:0] rem_ff, rem_in;
   logic signed [CRD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;

   logic signed [RED_W-1:0] z_full, lim, folded;
   logic signed [CRD_W-1:0] dx, dy, xf, yf, xr, yr;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      i_in = i_ff;
      zneg_in = zneg_ff;
      flip_in = flip_ff;
      rem_in = rem_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      z_full = {{(RED_W-WORD_W-Q30_SHIFT){angle[WORD_W-1]}}, angle, {Q30_SHIFT{1'b0}}};
      lim = Q30_TWO_PI <<< k_ff;
      folded = rem_ff;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               zneg_in = angle[WORD_W-1];
               rem_in = angle[WORD_W-1] ? -z_full : z_full;
               k_in = 4'd13;
               state_in = C_RED;
            end
         end
         C_RED: begin
            if (rem_ff >= lim) rem_in = rem_ff - lim;
            if (k_ff == 4'd0) state_in = C_FIX;
            else k_in = k_ff - 4'd1;
         end
         C_FIX: begin
            if (zneg_ff && rem_ff != '0) rem_in = Q30_TWO_PI - rem_ff;
            state_in = C_WRAP;
         end
         C_WRAP: begin
            if (rem_ff >= Q30_PI) rem_in = rem_ff - Q30_TWO_PI;
            state_in = C_FOLD;
         end
         C_FOLD: begin
            flip_in = 1'b0;
            if (rem_ff > Q30_HALF_PI) begin
               folded = rem_ff - Q30_PI;
               flip_in = 1'b1;
            end else if (rem_ff < -Q30_HALF_PI) begin
               folded = rem_ff + Q30_PI;
               flip_in = 1'b1;
            end
            z_in = folded[CRD_W-1:0];
            x_in = Q30_GAIN;
            y_in = '0;
            i_in = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[CRD_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_q30(i_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_q30(i_ff);
            end
            if (i_ff == 5'(CORDIC_STEPS - 1)) state_in = C_DONE;
            else i_in = i_ff + 5'd1;
         end
         C_DONE: state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
      i_ff <= i_in;
      zneg_ff <= zneg_in;
      flip_ff <= flip_in;
      rem_ff <= rem_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // half-LSB round then floor shift down to the output fraction
   always_comb begin
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
      xr = xf + CRD_W'(1 << (Q30_SHIFT - 1));
      yr = yf + CRD_W'(1 << (Q30_SHIFT - 1));
      result.done = (state_ff == C_DONE);
      result.cos_v = {{(WORD_W-CRD_W+Q30_SHIFT){xr[CRD_W-1]}}, xr[CRD_W-1:Q30_SHIFT]};
      result.sin_v = {{(WORD_W-CRD_W+Q30_SHIFT){yr[CRD_W-1]}}, yr[CRD_W-1:Q30_SHIFT]};
   end

endmodule

`default_nettype wire

### src/twmc_mul.sv
// Bit-serial signed fractional multiplier with rounding and saturation.
// Depends on twmc_pkg.
`default_nettype none

module twmc_mul (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire twmc_pkg::word_type a,
   input  wire twmc_pkg::word_type b,
   output twmc_pkg::mul_out_type   result
);
   import twmc_pkg::*;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_RUN  = 2'd1;
   localparam logic [1:0] M_FIN  = 2'd2;
   localparam int CNT_W = $clog2(WORD_W);
   localparam int PROD_W = 2 * WORD_W;
   localparam int MAG_W = PROD_W + 1 - FRAC_BITS;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, done_ff, done_in;
   logic [WORD_W-1:0] ua_ff, ua_in, ub_ff, ub_in, hi_ff, hi_in, lo_ff, lo_in;
   word_type prod_ff, prod_in;

   logic [WORD_W:0] sum;
   logic [PROD_W:0] rnd;
   logic [MAG_W-1:0] mag;
   logic over;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      ua_in = ua_ff;
      ub_in = ub_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      prod_in = prod_ff;
      done_in = 1'b0;
      sum = {1'b0, hi_ff} + {1'b0, (ub_ff[0] ? ua_ff : '0)};
      rnd = {1'b0, hi_ff, lo_ff} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
      mag = rnd[PROD_W:FRAC_BITS];
      over = |mag[MAG_W-1:WORD_W-1];
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               neg_in = a[WORD_W-1] ^ b[WORD_W-1];
               ua_in = a[WORD_W-1] ? WORD_W'(-a) : a;
               ub_in = b[WORD_W-1] ? WORD_W'(-b) : b;
               hi_in = '0;
               lo_in = '0;
               cnt_in = '0;
               state_in = M_RUN;
            end
         end
         M_RUN: begin
            hi_in = sum[WORD_W:1];
            lo_in = {sum[0], lo_ff[WORD_W-1:1]};
            ub_in = ub_ff >> 1;
            if (cnt_ff == CNT_W'(WORD_W - 1)) state_in = M_FIN;
            else cnt_in = cnt_ff + 1'b1;
         end
         M_FIN: begin
            if (!neg_ff) prod_in = over ? WORD_MAX : mag[WORD_W-1:0];
            else prod_in = over ? WORD_MIN : -mag[WORD_W-1:0];
            done_in = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      ua_ff <= ua_in;
      ub_ff <= ub_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      prod_ff <= prod_in;
   end

   assign result.done = done_ff;
   assign result.prod = prod_ff;

endmodule

`default_nettype wire

### src/trs_world_matrix_compose.sv
// World matrix compose: local = T * Rz * Ry * Rx * S, world = parent * local.
// Load and skip requests leave the block idle. An update runs the CORDIC for
// the three angles, one after another, then each product in turn on the shared
// bit-serial multiplier: 64 products per matrix product, 4 (root) or 5 (child).
// Requests stall from the start of an update until its last element is taken.
// Synchronous active-high reset: parent matrix to identity, load position to 0.
`default_nettype none

module trs_world_matrix_compose (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire [1:0]               req_cmd,
   input  wire twmc_pkg::word_type req_parent_element,
   input  wire twmc_pkg::word_type req_pos_x,
   input  wire twmc_pkg::word_type req_pos_y,
   input  wire twmc_pkg::word_type req_pos_z,
   input  wire twmc_pkg::word_type req_rot_x,
   input  wire twmc_pkg::word_type req_rot_y,
   input  wire twmc_pkg::word_type req_rot_z,
   input  wire twmc_pkg::word_type req_scale_x,
   input  wire twmc_pkg::word_type req_scale_y,
   input  wire twmc_pkg::word_type req_scale_z,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [3:0]              rsp_elem_index,
   output twmc_pkg::word_type      rsp_elem_value,
   output logic                    rsp_last_element
);
   import twmc_pkg::*;
   `include "trs_world_matrix_compose_assert.svh"

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ASTART = 3'd1;
   localparam logic [2:0] S_AWAIT  = 3'd2;
   localparam logic [2:0] S_MSTART = 3'd3;
   localparam logic [2:0] S_MWAIT  = 3'd4;
   localparam logic [2:0] S_COPY   = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   // operand matrix kinds
   localparam logic [2:0] K_RX = 3'd0;
   localparam logic [2:0] K_RY = 3'd1;
   localparam logic [2:0] K_RZ = 3'd2;
   localparam logic [2:0] K_SC = 3'd3;
   localparam logic [2:0] K_TR = 3'd4;

   // product steps, in order of evaluation
   localparam logic [2:0] P_RYRX   = 3'd0;
   localparam logic [2:0] P_RZ     = 3'd1;
   localparam logic [2:0] P_SCALE  = 3'd2;
   localparam logic [2:0] P_TRANS  = 3'd3;
   localparam logic [2:0] P_PARENT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [3:0] elem_ff, elem_in, load_pos_ff, load_pos_in, out_idx_ff, out_idx_in;
   logic [1:0] k_ff, k_in, ang_ff, ang_in, cmd_ff, cmd_in;
   logic rsp_valid_ff, rsp_valid_in;
   word_type acc_ff, acc_in;

   word_type parent_ff [16];
   word_type work_ff [16];
   word_type temp_ff [16];
   word_type sin_ff [3];
   word_type cos_ff [3];
   word_type pos_ff [3];
   word_type scl_ff [3];
   word_type rot_ff [3];

   logic cordic_start, mul_start;
   cordic_out_type cordic_out;
   mul_out_type mul_out;
   word_type op_l, op_r, acc_sum;
   logic [3:0] l_idx, r_idx;
   logic [2:0] last_step;
   logic req_take, rsp_take;

   // element of one of the factor matrices, identity where not overridden
   function automatic word_type build(input logic [2:0] kind, input logic [3:0] idx,
                                      input word_type s, input word_type c,
                                      input word_type f0, input word_type f1,
                                      input word_type f2);
      word_type v;
      v = (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) ? ONE_Q : '0;
      unique case (kind)
         K_RX: begin
            if (idx == 4'd5 || idx == 4'd10) v = c;
            if (idx == 4'd6) v = -s;
            if (idx == 4'd9) v = s;
         end
         K_RY: begin
            if (idx == 4'd0 || idx == 4'd10) v = c;
            if (idx == 4'd2) v = s;
            if (idx == 4'd8) v = -s;
         end
         K_RZ: begin
            if (idx == 4'd0 || idx == 4'd5) v = c;
            if (idx == 4'd1) v = -s;
            if (idx == 4'd4) v = s;
         end
         K_SC: begin
            if (idx == 4'd0) v = f0;
            if (idx == 4'd5) v = f1;
            if (idx == 4'd10) v = f2;
         end
         K_TR: begin
            if (idx == 4'd3) v = f0;
            if (idx == 4'd7) v = f1;
            if (idx == 4'd11) v = f2;
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic word_type sat_add(input word_type x, input word_type y);
      logic [WORD_W:0] s;
      s = {x[WORD_W-1], x} + {y[WORD_W-1], y};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
      return s[WORD_W-1:0];
   endfunction

   // operands of the current product: left[row][k] times right[k][col]
   always_comb begin
      l_idx = {elem_ff[3:2], k_ff};
      r_idx = {k_ff, elem_ff[1:0]};
      op_l = work_ff[l_idx];
      op_r = work_ff[r_idx];
      case (step_ff)
         P_RYRX: begin
            op_l = build(K_RY, l_idx, sin_ff[1], cos_ff[1], '0, '0, '0);
            op_r = build(K_RX, r_idx, sin_ff[0], cos_ff[0], '0, '0, '0);
         end
         P_RZ: op_l = build(K_RZ, l_idx, sin_ff[2], cos_ff[2], '0, '0, '0);
         P_SCALE: op_r = build(K_SC, r_idx, '0, '0, scl_ff[0], scl_ff[1], scl_ff[2]);
         P_TRANS: op_l = build(K_TR, l_idx, '0, '0, pos_ff[0], pos_ff[1], pos_ff[2]);
         P_PARENT: op_l = parent_ff[l_idx];
         default: op_l = work_ff[l_idx];
      endcase
   end

   twmc_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .angle  (rot_ff[ang_ff]),
      .result (cordic_out)
   );

   twmc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (op_l),
      .b      (op_r),
      .result (mul_out)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign cordic_start = (state_ff == S_ASTART);
   assign mul_start = (state_ff == S_MSTART);
   assign last_step = (cmd_ff == CMD_CHILD) ? P_PARENT : P_TRANS;
   // first term of each element starts from zero
   assign acc_sum = sat_add((k_ff == 2'd0) ? '0 : acc_ff, mul_out.prod);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      elem_in = elem_ff;
      k_in = k_ff;
      ang_in = ang_ff;
      cmd_in = cmd_ff;
      load_pos_in = load_pos_ff;
      out_idx_in = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      acc_in = acc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in = req_cmd;
               unique case (req_cmd)
                  CMD_LOAD: load_pos_in = load_pos_ff + 4'd1;
                  CMD_CHILD, CMD_ROOT: begin
                     ang_in = 2'd0;
                     state_in = S_ASTART;
                  end
                  CMD_SKIP: state_in = S_IDLE;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ASTART: state_in = S_AWAIT;
         S_AWAIT: begin
            if (cordic_out.done) begin
               if (ang_ff == 2'd2) begin
                  step_in = P_RYRX;
                  elem_in = '0;
                  k_in = '0;
                  state_in = S_MSTART;
               end else begin
                  ang_in = ang_ff + 2'd1;
                  state_in = S_ASTART;
               end
            end
         end
         S_MSTART: state_in = S_MWAIT;
         S_MWAIT: begin
            if (mul_out.done) begin
               acc_in = acc_sum;
               state_in = S_MSTART;
               if (k_ff == 2'd3) begin
                  k_in = '0;
                  if (elem_ff == 4'd15) state_in = S_COPY;
                  else elem_in = elem_ff + 4'd1;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_COPY: begin
            elem_in = '0;
            if (step_ff == last_step) begin
               out_idx_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               step_in = step_ff + 3'd1;
               state_in = S_MSTART;
            end
         end
         S_OUT: begin
            if (rsp_take) begin
               if (out_idx_ff == 4'd15) begin
                  rsp_valid_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 4'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         load_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            parent_ff[i] <= (i % 5 == 0) ? ONE_Q : '0;
         end
      end else begin
         state_ff <= state_in;
         load_pos_ff <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take && req_cmd == CMD_LOAD) parent_ff[load_pos_ff] <= req_parent_element;
      end
      step_ff <= step_in;
      elem_ff <= elem_in;
      k_ff <= k_in;
      ang_ff <= ang_in;
      cmd_ff <= cmd_in;
      out_idx_ff <= out_idx_in;
      acc_ff <= acc_in;
      if (req_take) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         rot_ff[0] <= req_rot_x;
         rot_ff[1] <= req_rot_y;
         rot_ff[2] <= req_rot_z;
         scl_ff[0] <= req_scale_x;
         scl_ff[1] <= req_scale_y;
         scl_ff[2] <= req_scale_z;
      end
      if (state_ff == S_AWAIT && cordic_out.done) begin
         sin_ff[ang_ff] <= cordic_out.sin_v;
         cos_ff[ang_ff] <= cordic_out.cos_v;
      end
      if (state_ff == S_MWAIT && mul_out.done && k_ff == 2'd3) temp_ff[elem_ff] <= acc_sum;
      if (state_ff == S_COPY) work_ff <= temp_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_elem_index = out_idx_ff;
   assign rsp_elem_value = work_ff[out_idx_ff];
   assign rsp_last_element = (out_idx_ff == 4'd15);

   // no new request while a matrix is being delivered
   `TWMC_ASSERT_NOW(a_rsp_holds_req, rsp_valid, req_stall, "request taken during output")
   // the last element closes the burst
   `TWMC_ASSERT_NEXT(a_last_ends, rsp_take && rsp_last_element, !rsp_valid,
                     "output continued past last element")
   // multiplier results only arrive while the sequencer waits for them
   `TWMC_ASSERT_NOW(a_mul_done_wait, mul_out.done, state_ff == S_MWAIT,
                    "multiplier result outside wait state")

endmodule

`default_nettype wire
